>>> design/fd4l_pkg.sv
package fd4l_pkg;

   // Grid geometry and sample format.
   localparam int MAX_ROW_LENGTH = 4096;
   localparam int COL_W          = $clog2(MAX_ROW_LENGTH);
   localparam int LEN_W          = COL_W + 1;
   localparam int ROWS_W         = 16;
   localparam int SAMPLE_W       = 24;

   // One line memory word holds one column of the four stored rows.
   localparam int NUM_SLOTS = 4;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);
   localparam int WORD_W    = NUM_SLOTS * SAMPLE_W;

   // Arithmetic widths.
   localparam int COEF_W    = 32;
   localparam int NUM_COEF  = 5;
   localparam int PSUM_W    = SAMPLE_W + 1;
   localparam int PROD_W    = COEF_W + PSUM_W;
   localparam int ACC_W     = PROD_W + 3;
   localparam int FRAC_BITS = 24;
   localparam int RESULT_W  = 32;

   // Result queue.
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
   localparam int STALL_W    = FIFO_CNT_W + 1;

   // Register reset values.
   localparam logic [LEN_W-1:0]         ROW_LENGTH_RESET = LEN_W'(4096);
   localparam logic [ROWS_W-1:0]        ROW_COUNT_RESET  = ROWS_W'(4096);
   localparam logic signed [COEF_W-1:0] NEAR_COEF_RESET  = 32'sd22369621;
   localparam logic signed [COEF_W-1:0] FAR_COEF_RESET   = -32'sd1398101;
   localparam logic signed [COEF_W-1:0] CENTER_RESET     = -32'sd83886080;

   // Coefficient slots, ordered the same way as the pre-added tap pairs.
   localparam int COEF_NEAR_FAST = 0;
   localparam int COEF_FAR_FAST  = 1;
   localparam int COEF_NEAR_SLOW = 2;
   localparam int COEF_FAR_SLOW  = 3;
   localparam int COEF_CENTER    = 4;

   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_LENGTH = 3'd0,
      CSR_ROW_COUNT  = 3'd1,
      CSR_NEAR_FAST  = 3'd2,
      CSR_FAR_FAST   = 3'd3,
      CSR_NEAR_SLOW  = 3'd4,
      CSR_FAR_SLOW   = 3'd5,
      CSR_CENTER     = 3'd6
   } csr_index_type;

   // Control that travels down the arithmetic pipeline with each beat.
   typedef struct packed {
      logic              valid;
      logic              emit;
      logic              last;
      logic [ROWS_W-1:0] row;
      logic [COL_W-1:0]  col;
   } ctl_type;

   // One queued result.
   typedef struct packed {
      logic signed [RESULT_W-1:0] lap;
      logic [ROWS_W-1:0]          row;
      logic [COL_W-1:0]           col;
      logic                       last;
   } result_type;

endpackage

>>> design/fd4_laplacian_stencil_2d.sv
// Fourth-order 2-D Laplacian over a grid streamed in raster order.
// The req channel carries one signed sample per beat, fast axis first; the
// block keeps its own row and column position and wraps to the next grid
// after the last sample of the last row.  For every interior point (two or
// more samples from each edge) one beat leaves on the rsp channel with the
// rounded, saturated Laplacian, the point's row and column, and a flag on
// the last interior point of the grid.  Border points give no beat.
// Throughput is one sample per clock while req_stall is low: each beat
// does one read-modify-write of a column word in the line memory plus one
// look-ahead read two columns on, and the arithmetic is fully pipelined.
// A result enters the queue from the end of the pipeline started by the
// sample two rows below the center point, which completes its cross window.
// The results sit in a small queue; when rsp_stall is held the queue fills
// and req_stall rises before anything can be lost.  The csr port writes the
// geometry and the five Q8.24 weights and should be used while idle.
// Reset is synchronous: it clears the position, the pipeline and the queue
// and restores the default weights.  The line memory is not cleared; every
// entry read for a result was written earlier in the same grid.
module fd4_laplacian_stencil_2d (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [fd4l_pkg::SAMPLE_W-1:0]    req_sample,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [fd4l_pkg::RESULT_W-1:0]    rsp_lap_value,
   output logic [fd4l_pkg::ROWS_W-1:0]             rsp_out_row,
   output logic [fd4l_pkg::COL_W-1:0]              rsp_out_col,
   output logic                                    rsp_frame_last,
   input  logic                                    csr_wr_en,
   input  logic [fd4l_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [fd4l_pkg::COEF_W-1:0]             csr_wdata
);

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   logic [fd4l_pkg::LEN_W-1:0]          row_length_ff;
   logic [fd4l_pkg::ROWS_W-1:0]         row_count_ff;
   logic signed [fd4l_pkg::COEF_W-1:0]  coef_ff [fd4l_pkg::NUM_COEF];

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff                        <= fd4l_pkg::ROW_LENGTH_RESET;
         row_count_ff                         <= fd4l_pkg::ROW_COUNT_RESET;
         coef_ff[fd4l_pkg::COEF_NEAR_FAST]    <= fd4l_pkg::NEAR_COEF_RESET;
         coef_ff[fd4l_pkg::COEF_FAR_FAST]     <= fd4l_pkg::FAR_COEF_RESET;
         coef_ff[fd4l_pkg::COEF_NEAR_SLOW]    <= fd4l_pkg::NEAR_COEF_RESET;
         coef_ff[fd4l_pkg::COEF_FAR_SLOW]     <= fd4l_pkg::FAR_COEF_RESET;
         coef_ff[fd4l_pkg::COEF_CENTER]       <= fd4l_pkg::CENTER_RESET;
      end else if (csr_wr_en) begin
         unique case (fd4l_pkg::csr_index_type'(csr_index))
            fd4l_pkg::CSR_ROW_LENGTH: begin
               row_length_ff <= csr_wdata[fd4l_pkg::LEN_W-1:0];
            end
            fd4l_pkg::CSR_ROW_COUNT: begin
               row_count_ff <= csr_wdata[fd4l_pkg::ROWS_W-1:0];
            end
            fd4l_pkg::CSR_NEAR_FAST: begin
               coef_ff[fd4l_pkg::COEF_NEAR_FAST] <= csr_wdata;
            end
            fd4l_pkg::CSR_FAR_FAST: begin
               coef_ff[fd4l_pkg::COEF_FAR_FAST] <= csr_wdata;
            end
            fd4l_pkg::CSR_NEAR_SLOW: begin
               coef_ff[fd4l_pkg::COEF_NEAR_SLOW] <= csr_wdata;
            end
            fd4l_pkg::CSR_FAR_SLOW: begin
               coef_ff[fd4l_pkg::COEF_FAR_SLOW] <= csr_wdata;
            end
            fd4l_pkg::CSR_CENTER: begin
               coef_ff[fd4l_pkg::COEF_CENTER] <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // A zero length acts as one, and lengths beyond the memory are clipped.
   logic [fd4l_pkg::LEN_W-1:0]  eff_len;
   logic [fd4l_pkg::ROWS_W-1:0] eff_rows;

   always_comb begin
      if (row_length_ff == '0) begin
         eff_len = fd4l_pkg::LEN_W'(1);
      end else if (row_length_ff > fd4l_pkg::LEN_W'(fd4l_pkg::MAX_ROW_LENGTH)) begin
         eff_len = fd4l_pkg::LEN_W'(fd4l_pkg::MAX_ROW_LENGTH);
      end else begin
         eff_len = row_length_ff;
      end
      eff_rows = (row_count_ff == '0) ? fd4l_pkg::ROWS_W'(1) : row_count_ff;
   end

   // ---------------------------------------------------------------------
   // Raster position and the decision whether this sample closes a window.
   // ---------------------------------------------------------------------
   logic [fd4l_pkg::COL_W-1:0]  col_pos_ff;
   logic [fd4l_pkg::ROWS_W-1:0] row_pos_ff;
   logic                        req_accept;
   logic [fd4l_pkg::LEN_W-1:0]  col_ext;
   logic [fd4l_pkg::LEN_W-1:0]  col_next;
   logic [fd4l_pkg::ROWS_W:0]   row_next;
   logic                        in_row;
   logic                        emit_now;
   logic                        last_now;

   assign req_accept = req_valid && !req_stall;
   assign col_ext    = {1'b0, col_pos_ff};
   assign col_next   = col_ext + fd4l_pkg::LEN_W'(1);
   assign row_next   = {1'b0, row_pos_ff} + (fd4l_pkg::ROWS_W + 1)'(1);
   assign in_row     = col_ext < eff_len;

   // The window centered two rows up is interior only if both axes leave
   // two samples of margin on each side.
   assign emit_now = in_row && (row_pos_ff < eff_rows)
                     && (row_pos_ff >= fd4l_pkg::ROWS_W'(4))
                     && (eff_len >= fd4l_pkg::LEN_W'(5))
                     && (col_pos_ff >= fd4l_pkg::COL_W'(2))
                     && ((col_ext + fd4l_pkg::LEN_W'(2)) < eff_len);
   assign last_now = (row_next == {1'b0, eff_rows})
                     && ((col_ext + fd4l_pkg::LEN_W'(3)) == eff_len);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
      end else if (req_accept) begin
         if (col_next >= eff_len) begin
            col_pos_ff <= '0;
            row_pos_ff <= (row_next >= {1'b0, eff_rows}) ? '0
                                                         : row_next[fd4l_pkg::ROWS_W-1:0];
         end else begin
            col_pos_ff <= col_next[fd4l_pkg::COL_W-1:0];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Line memory: one word per column, slot (row mod 4) holds that row.
   // Port A reads the current column for the read-modify-write, port B
   // reads two columns ahead for the right end of the horizontal arm.
   // ---------------------------------------------------------------------
   logic [fd4l_pkg::WORD_W-1:0] line_mem [fd4l_pkg::MAX_ROW_LENGTH];
   logic [fd4l_pkg::WORD_W-1:0] rd_a_ff;
   logic [fd4l_pkg::WORD_W-1:0] rd_b_ff;
   logic [fd4l_pkg::COL_W-1:0]  addr_b;

   // First pipeline stage: the beat whose memory words are now available.
   fd4l_pkg::ctl_type                    s1_ctl_ff;
   logic                                 s1_wr_ff;
   logic [fd4l_pkg::COL_W-1:0]           s1_addr_ff;
   logic [fd4l_pkg::SLOT_W-1:0]          s1_slot_ff;
   logic signed [fd4l_pkg::SAMPLE_W-1:0] s1_sample_ff;
   logic [fd4l_pkg::WORD_W-1:0]          merged;

   assign addr_b = col_pos_ff + fd4l_pkg::COL_W'(2);

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_a_ff <= line_mem[col_pos_ff];
         rd_b_ff <= line_mem[addr_b];
      end
      if (s1_wr_ff) begin
         line_mem[s1_addr_ff] <= merged;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s1_wr_ff  <= 1'b0;
      end else begin
         s1_ctl_ff.valid <= req_accept;
         s1_ctl_ff.emit  <= req_accept && emit_now;
         s1_ctl_ff.last  <= last_now;
         s1_ctl_ff.row   <= row_pos_ff - fd4l_pkg::ROWS_W'(2);
         s1_ctl_ff.col   <= col_pos_ff;
         s1_wr_ff        <= req_accept && in_row;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_addr_ff   <= col_pos_ff;
         s1_slot_ff   <= row_pos_ff[fd4l_pkg::SLOT_W-1:0];
         s1_sample_ff <= req_sample;
      end
   end

   // When the same column is read at the edge that writes it back (rows one
   // sample long), the read returns the old word; the written word is
   // forwarded instead.
   logic                        fwd_valid_ff;
   logic [fd4l_pkg::COL_W-1:0]  fwd_addr_ff;
   logic [fd4l_pkg::WORD_W-1:0] fwd_word_ff;
   logic [fd4l_pkg::WORD_W-1:0] word_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= s1_wr_ff;
      end
   end

   always_ff @(posedge clock) begin
      fwd_addr_ff <= s1_addr_ff;
      fwd_word_ff <= merged;
   end

   assign word_a = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_word_ff : rd_a_ff;

   always_comb begin
      merged = word_a;
      merged[s1_slot_ff*fd4l_pkg::SAMPLE_W +: fd4l_pkg::SAMPLE_W] = s1_sample_ff;
   end

   // Taps of the cross.  The current row is r, so rows r-1..r-4 sit in the
   // slots one to four below it, modulo four.
   logic [fd4l_pkg::SLOT_W-1:0]          slot_m1;
   logic [fd4l_pkg::SLOT_W-1:0]          slot_m2;
   logic [fd4l_pkg::SLOT_W-1:0]          slot_m3;
   logic signed [fd4l_pkg::SAMPLE_W-1:0] tap_up1;
   logic signed [fd4l_pkg::SAMPLE_W-1:0] tap_center;
   logic signed [fd4l_pkg::SAMPLE_W-1:0] tap_up3;
   logic signed [fd4l_pkg::SAMPLE_W-1:0] tap_up4;
   logic signed [fd4l_pkg::SAMPLE_W-1:0] tap_right2;

   assign slot_m1 = s1_slot_ff - fd4l_pkg::SLOT_W'(1);
   assign slot_m2 = s1_slot_ff - fd4l_pkg::SLOT_W'(2);
   assign slot_m3 = s1_slot_ff - fd4l_pkg::SLOT_W'(3);

   assign tap_up1    = signed'(word_a[slot_m1*fd4l_pkg::SAMPLE_W +: fd4l_pkg::SAMPLE_W]);
   assign tap_center = signed'(word_a[slot_m2*fd4l_pkg::SAMPLE_W +: fd4l_pkg::SAMPLE_W]);
   assign tap_up3    = signed'(word_a[slot_m3*fd4l_pkg::SAMPLE_W +: fd4l_pkg::SAMPLE_W]);
   assign tap_up4    = signed'(word_a[s1_slot_ff*fd4l_pkg::SAMPLE_W +: fd4l_pkg::SAMPLE_W]);
   assign tap_right2 = signed'(rd_b_ff[slot_m2*fd4l_pkg::SAMPLE_W +: fd4l_pkg::SAMPLE_W]);

   // Horizontal arm history of the center row: columns c-1 and c-2 from
   // earlier port A reads, column c+1 from the previous port B read.
   logic signed [fd4l_pkg::SAMPLE_W-1:0] win_left_ff [2];
   logic signed [fd4l_pkg::SAMPLE_W-1:0] win_right1_ff;

   always_ff @(posedge clock) begin
      if (s1_ctl_ff.valid) begin
         win_left_ff[0] <= tap_center;
         win_left_ff[1] <= win_left_ff[0];
         win_right1_ff  <= tap_right2;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: pairs that share a weight are added first.
   // ---------------------------------------------------------------------
   fd4l_pkg::ctl_type                  s2_ctl_ff;
   logic signed [fd4l_pkg::PSUM_W-1:0] psum_ff [fd4l_pkg::NUM_COEF];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else begin
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      psum_ff[fd4l_pkg::COEF_NEAR_FAST] <= fd4l_pkg::PSUM_W'(win_left_ff[0])
                                           + fd4l_pkg::PSUM_W'(win_right1_ff);
      psum_ff[fd4l_pkg::COEF_FAR_FAST]  <= fd4l_pkg::PSUM_W'(win_left_ff[1])
                                           + fd4l_pkg::PSUM_W'(tap_right2);
      psum_ff[fd4l_pkg::COEF_NEAR_SLOW] <= fd4l_pkg::PSUM_W'(tap_up3)
                                           + fd4l_pkg::PSUM_W'(tap_up1);
      psum_ff[fd4l_pkg::COEF_FAR_SLOW]  <= fd4l_pkg::PSUM_W'(tap_up4)
                                           + fd4l_pkg::PSUM_W'(s1_sample_ff);
      psum_ff[fd4l_pkg::COEF_CENTER]    <= fd4l_pkg::PSUM_W'(tap_center);
   end

   // ---------------------------------------------------------------------
   // Stage 3: five multipliers, 25 x 32 bits each.
   // ---------------------------------------------------------------------
   fd4l_pkg::ctl_type                  s3_ctl_ff;
   logic signed [fd4l_pkg::PROD_W-1:0] prod_ff [fd4l_pkg::NUM_COEF];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
      end else begin
         s3_ctl_ff <= s2_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < fd4l_pkg::NUM_COEF; k++) begin
         prod_ff[k] <= psum_ff[k] * coef_ff[k];
      end
   end

   // ---------------------------------------------------------------------
   // Stages 4 and 5: adder tree.  The rounding half is folded in here, so
   // the final shift is a plain floor.
   // ---------------------------------------------------------------------
   fd4l_pkg::ctl_type                 s4_ctl_ff;
   fd4l_pkg::ctl_type                 s5_ctl_ff;
   logic signed [fd4l_pkg::ACC_W-1:0] acc_a_ff;
   logic signed [fd4l_pkg::ACC_W-1:0] acc_b_ff;
   logic signed [fd4l_pkg::ACC_W-1:0] acc_c_ff;
   logic signed [fd4l_pkg::ACC_W-1:0] acc_ab_ff;
   logic signed [fd4l_pkg::ACC_W-1:0] acc_c2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ctl_ff <= '0;
         s5_ctl_ff <= '0;
      end else begin
         s4_ctl_ff <= s3_ctl_ff;
         s5_ctl_ff <= s4_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_a_ff  <= fd4l_pkg::ACC_W'(prod_ff[fd4l_pkg::COEF_NEAR_FAST])
                   + fd4l_pkg::ACC_W'(prod_ff[fd4l_pkg::COEF_FAR_FAST]);
      acc_b_ff  <= fd4l_pkg::ACC_W'(prod_ff[fd4l_pkg::COEF_NEAR_SLOW])
                   + fd4l_pkg::ACC_W'(prod_ff[fd4l_pkg::COEF_FAR_SLOW]);
      acc_c_ff  <= fd4l_pkg::ACC_W'(prod_ff[fd4l_pkg::COEF_CENTER])
                   + (fd4l_pkg::ACC_W'(1) <<< (fd4l_pkg::FRAC_BITS - 1));
      acc_ab_ff <= acc_a_ff + acc_b_ff;
      acc_c2_ff <= acc_c_ff;
   end

   // Final add, shift by the fraction width and saturate to 32 bits: the
   // value fits when every bit above the result's sign matches it.
   logic signed [fd4l_pkg::ACC_W-1:0]    acc_total;
   logic [fd4l_pkg::ACC_W-fd4l_pkg::FRAC_BITS-fd4l_pkg::RESULT_W:0] acc_top;
   logic signed [fd4l_pkg::RESULT_W-1:0] lap_sat;

   assign acc_total = acc_ab_ff + acc_c2_ff;
   assign acc_top   = acc_total[fd4l_pkg::ACC_W-1:fd4l_pkg::FRAC_BITS+fd4l_pkg::RESULT_W-1];

   always_comb begin
      if ((acc_top == '0) || (acc_top == '1)) begin
         lap_sat = acc_total[fd4l_pkg::FRAC_BITS +: fd4l_pkg::RESULT_W];
      end else if (acc_total[fd4l_pkg::ACC_W-1]) begin
         lap_sat = {1'b1, {(fd4l_pkg::RESULT_W-1){1'b0}}};
      end else begin
         lap_sat = {1'b0, {(fd4l_pkg::RESULT_W-1){1'b1}}};
      end
   end

   // ---------------------------------------------------------------------
   // Result queue.  The input stalls once the queue plus every beat still
   // in the pipeline could fill it, so a held rsp_stall never drops data.
   // ---------------------------------------------------------------------
   fd4l_pkg::result_type               fifo_mem [fd4l_pkg::FIFO_DEPTH];
   logic [fd4l_pkg::FIFO_PTR_W-1:0]    wr_ptr_ff;
   logic [fd4l_pkg::FIFO_PTR_W-1:0]    rd_ptr_ff;
   logic [fd4l_pkg::FIFO_CNT_W-1:0]    fifo_count_ff;
   logic                               push;
   logic                               pop;
   logic [fd4l_pkg::STALL_W-1:0]       inflight;
   fd4l_pkg::result_type               head;

   assign push = s5_ctl_ff.valid && s5_ctl_ff.emit;
   assign pop  = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= '{lap:  lap_sat,
                                  row:  s5_ctl_ff.row,
                                  col:  s5_ctl_ff.col,
                                  last: s5_ctl_ff.last};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + fd4l_pkg::FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + fd4l_pkg::FIFO_PTR_W'(1);
         end
         if (push && !pop) begin
            fifo_count_ff <= fifo_count_ff + fd4l_pkg::FIFO_CNT_W'(1);
         end else if (pop && !push) begin
            fifo_count_ff <= fifo_count_ff - fd4l_pkg::FIFO_CNT_W'(1);
         end
      end
   end

   assign inflight = fd4l_pkg::STALL_W'(s1_ctl_ff.valid) + fd4l_pkg::STALL_W'(s2_ctl_ff.valid)
                     + fd4l_pkg::STALL_W'(s3_ctl_ff.valid) + fd4l_pkg::STALL_W'(s4_ctl_ff.valid)
                     + fd4l_pkg::STALL_W'(s5_ctl_ff.valid);

   assign req_stall = (fd4l_pkg::STALL_W'(fifo_count_ff) + inflight)
                      >= fd4l_pkg::STALL_W'(fd4l_pkg::FIFO_DEPTH);

   assign head           = fifo_mem[rd_ptr_ff];
   assign rsp_valid      = fifo_count_ff != '0;
   assign rsp_lap_value  = head.lap;
   assign rsp_out_row    = head.row;
   assign rsp_out_col    = head.col;
   assign rsp_frame_last = head.last;

endmodule

>>> design/fd4l_checker.sv
module fd4l_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic signed [fd4l_pkg::SAMPLE_W-1:0] req_sample,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [fd4l_pkg::RESULT_W-1:0] rsp_lap_value,
   input logic [fd4l_pkg::ROWS_W-1:0]          rsp_out_row,
   input logic [fd4l_pkg::COL_W-1:0]           rsp_out_col,
   input logic                                 rsp_frame_last,
   input logic                                 csr_wr_en,
   input logic [fd4l_pkg::CSR_IDX_W-1:0]       csr_index,
   input logic [fd4l_pkg::COEF_W-1:0]          csr_wdata
);

   // A stalled result beat holds its valid and its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_lap_value)
         && $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_frame_last))
      else $error("stalled result beat changed");

   // Reset empties the pipeline and the result queue.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not empty after reset");

   // Without a sample after reset, no result can appear.
   assert property (@(posedge clock)
      $past(reset) && !reset && !(req_valid && !req_stall) |=> !rsp_valid)
      else $error("result without any accepted sample");

   // Reported points are never in the first two rows or the first two columns.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_row >= fd4l_pkg::ROWS_W'(2))
         && (rsp_out_col >= fd4l_pkg::COL_W'(2)))
      else $error("border point reported");

endmodule

bind fd4_laplacian_stencil_2d fd4l_checker u_fd4l_checker (.*);

>>> verif/fd4l_result_check.sv
`timescale 1ns / 1ps

module fd4l_result_check
   import fd4l_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic signed [RESULT_W-1:0] rsp_lap_value,
   input  logic [ROWS_W-1:0]          rsp_out_row,
   input  logic [COL_W-1:0]           rsp_out_col,
   input  logic                       rsp_frame_last,
   input  logic                       csr_wr_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [COEF_W-1:0]          csr_wdata,
   output int                         fail_count,
   output int                         pending
);

   localparam longint LAP_MAX = 64'sd2147483647;
   localparam longint LAP_MIN = -64'sd2147483648;

   // Mirror of the four stored rows; row r lives in slot r mod 4.
   logic signed [SAMPLE_W-1:0] line_mem [NUM_SLOTS * MAX_ROW_LENGTH];
   logic [LEN_W-1:0]           cfg_len;
   logic [ROWS_W-1:0]          cfg_rows;
   logic signed [COEF_W-1:0]   weight [NUM_COEF];
   int unsigned                grid_row;
   int unsigned                grid_col;
   result_type                 lap_q [$];

   function automatic longint line_tap(int unsigned row, int unsigned col);
      return longint'(line_mem[(row % NUM_SLOTS) * MAX_ROW_LENGTH + col % MAX_ROW_LENGTH]);
   endfunction

   // Advances the grid position by one sample and returns 1 with the
   // Laplacian of the point two rows up when that point is interior.
   function automatic bit laplacian_step(input logic signed [SAMPLE_W-1:0] fresh,
                                         output result_type res);
      int unsigned cols;
      int unsigned rows;
      int unsigned r;
      int unsigned c;
      int unsigned rc;
      longint      acc;
      longint      lap;
      bit          interior;
      cols = (cfg_len == 0) ? 1 : ((cfg_len > MAX_ROW_LENGTH) ? MAX_ROW_LENGTH : cfg_len);
      rows = (cfg_rows == 0) ? 1 : cfg_rows;
      r = grid_row;
      c = grid_col;
      rc = r - 2;
      res = '0;
      interior = c < cols && r < rows && r >= 4 && cols >= 5 && c >= 2 && c + 2 < cols;
      if (interior) begin
         // The sample in hand is the far tap below; slot r-4 still holds the one above.
         acc = longint'(weight[COEF_NEAR_FAST]) * (line_tap(rc, c - 1) + line_tap(rc, c + 1))
             + longint'(weight[COEF_FAR_FAST])  * (line_tap(rc, c - 2) + line_tap(rc, c + 2))
             + longint'(weight[COEF_NEAR_SLOW]) * (line_tap(r - 3, c) + line_tap(r - 1, c))
             + longint'(weight[COEF_FAR_SLOW])  * (line_tap(r - 4, c) + longint'(fresh))
             + longint'(weight[COEF_CENTER])    * line_tap(rc, c);
         lap = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
         if (lap > LAP_MAX) lap = LAP_MAX;
         else if (lap < LAP_MIN) lap = LAP_MIN;
         res.lap  = lap[RESULT_W-1:0];
         res.row  = rc[ROWS_W-1:0];
         res.col  = c[COL_W-1:0];
         res.last = (r + 1 == rows) && (c + 3 == cols);
      end
      if (c < cols) line_mem[(r % NUM_SLOTS) * MAX_ROW_LENGTH + c] = fresh;
      if (c + 1 >= cols) begin
         grid_col = 0;
         grid_row = (r + 1 >= rows) ? 0 : r + 1;
      end else begin
         grid_col = c + 1;
      end
      return interior;
   endfunction

   task automatic compare_field(string field, logic signed [RESULT_W:0] want,
                                logic signed [RESULT_W:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         cfg_len                = ROW_LENGTH_RESET;
         cfg_rows               = ROW_COUNT_RESET;
         weight[COEF_NEAR_FAST] = NEAR_COEF_RESET;
         weight[COEF_FAR_FAST]  = FAR_COEF_RESET;
         weight[COEF_NEAR_SLOW] = NEAR_COEF_RESET;
         weight[COEF_FAR_SLOW]  = FAR_COEF_RESET;
         weight[COEF_CENTER]    = CENTER_RESET;
         grid_row               = 0;
         grid_col               = 0;
         fail_count             = 0;
         lap_q.delete();
      end else begin
         // Results are retired before the new sample is predicted, so a beat
         // leaving now can never be matched against this cycle's prediction.
         if (rsp_valid && !rsp_stall) begin
            if (lap_q.size() == 0) begin
               $error("rsp beat at row %0d col %0d with no result pending",
                      rsp_out_row, rsp_out_col);
               fail_count++;
            end else begin
               want = lap_q.pop_front();
               compare_field("lap_value", want.lap, rsp_lap_value);
               compare_field("out_row", want.row, rsp_out_row);
               compare_field("out_col", want.col, rsp_out_col);
               compare_field("frame_last", want.last, rsp_frame_last);
            end
         end
         if (req_valid && !req_stall) begin
            if (laplacian_step(req_sample, want)) lap_q.push_back(want);
         end
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_ROW_LENGTH: cfg_len                = csr_wdata[LEN_W-1:0];
               CSR_ROW_COUNT:  cfg_rows               = csr_wdata[ROWS_W-1:0];
               CSR_NEAR_FAST:  weight[COEF_NEAR_FAST] = csr_wdata;
               CSR_FAR_FAST:   weight[COEF_FAR_FAST]  = csr_wdata;
               CSR_NEAR_SLOW:  weight[COEF_NEAR_SLOW] = csr_wdata;
               CSR_FAR_SLOW:   weight[COEF_FAR_SLOW]  = csr_wdata;
               CSR_CENTER:     weight[COEF_CENTER]    = csr_wdata;
               default: ;
            endcase
         end
      end
      pending <= lap_q.size();
   end

endmodule

>>> verif/tb_fd4_laplacian_stencil_2d.sv
`timescale 1ns / 1ps

module tb_fd4_laplacian_stencil_2d;
   import fd4l_pkg::*;

   // Results pass the pipeline and queue after the beat that completes
   // their window; settle covers that with margin before any register write.
   localparam int SETTLE_CYCLES = 16;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic [COEF_W-1:0]          WEIGHT_MAX = 32'h7FFF_FFFF;
   localparam logic [COEF_W-1:0]          WEIGHT_MIN = 32'h8000_0000;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_valid  = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_stall  = 1'b0;
   logic signed [RESULT_W-1:0] rsp_lap_value;
   logic [ROWS_W-1:0]          rsp_out_row;
   logic [COL_W-1:0]           rsp_out_col;
   logic                       rsp_frame_last;
   logic                       csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index  = '0;
   logic [COEF_W-1:0]          csr_wdata  = '0;
   int                         fail_count;
   int                         pending;

   // Percent chance per cycle that the sample source holds back a beat and
   // that the result sink stalls.  The main sequence changes these by segment.
   int tx_idle_pct = 7;
   int rx_idle_pct = 51;

   always #6 clock = ~clock;

   fd4_laplacian_stencil_2d uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_lap_value  (rsp_lap_value),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_frame_last (rsp_frame_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // The checker sits beside the block, watches both channels and the
   // register port, and keeps its own model of the grid.
   fd4l_result_check result_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_lap_value  (rsp_lap_value),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_frame_last (rsp_frame_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   // The sink stalls independently of anything else, one draw per cycle.
   always @(posedge clock) begin
      rsp_stall <= (rx_idle_pct > 0) && ($urandom_range(99) < rx_idle_pct);
   end

   // Samples lean on the extremes of the 24-bit range and on small values
   // near zero, so that both saturation and fine rounding are exercised.
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return SAMPLE_W'(int'($urandom_range(64)) - 32);
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   // Half the weights are small perturbations of the usual stencil values,
   // which keeps results in range; the rest are extremes or raw random words.
   function automatic logic [COEF_W-1:0] pick_weight(logic [COEF_W-1:0] nominal);
      case ($urandom_range(7))
         0:       return WEIGHT_MAX;
         1:       return WEIGHT_MIN;
         2, 3:    return $urandom();
         default: return nominal + $urandom_range(1 << 22) - (1 << 21);
      endcase
   endfunction

   // All tasks are entered and left right after a rising edge.  A write holds
   // the enable high for exactly one edge, then drops it and waits again, so
   // back-to-back writes never assign the enable twice in one step.
   task automatic csr_write(csr_index_type idx, logic [COEF_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_weights(logic [COEF_W-1:0] near_fast, logic [COEF_W-1:0] far_fast,
                              logic [COEF_W-1:0] near_slow, logic [COEF_W-1:0] far_slow,
                              logic [COEF_W-1:0] center);
      csr_write(CSR_NEAR_FAST, near_fast);
      csr_write(CSR_FAR_FAST, far_fast);
      csr_write(CSR_NEAR_SLOW, near_slow);
      csr_write(CSR_FAR_SLOW, far_slow);
      csr_write(CSR_CENTER, center);
   endtask

   task automatic shuffle_weights();
      set_weights(pick_weight(NEAR_COEF_RESET), pick_weight(FAR_COEF_RESET),
                  pick_weight(NEAR_COEF_RESET), pick_weight(FAR_COEF_RESET),
                  pick_weight(CENTER_RESET));
   endtask

   // One beat on the sample channel.  Idle cycles come first with valid low;
   // once raised, valid and the payload hold until the block takes the beat.
   task automatic send_sample(logic signed [SAMPLE_W-1:0] value);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stops the source until every predicted result has left the block, then
   // lets the pipeline run empty so that a register write finds it idle.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sets the geometry and streams whole grids, so that the position is back
   // at the first sample of a grid when the run moves on.  A row length of
   // zero behaves as one and anything past the line memory as its full size;
   // a row count of zero behaves as one.
   task automatic run_grids(int unsigned len, int unsigned rows, int unsigned grids);
      int unsigned cols;
      int unsigned depth;
      cols  = (len == 0) ? 1 : ((len > MAX_ROW_LENGTH) ? MAX_ROW_LENGTH : len);
      depth = (rows == 0) ? 1 : rows;
      csr_write(CSR_ROW_LENGTH, len);
      csr_write(CSR_ROW_COUNT, rows);
      repeat (grids * cols * depth) send_sample(pick_sample());
      settle();
   endtask

   // Mostly small grids, so that most samples land near a border or a wrap;
   // now and then a wider one with only the minimum of five rows.
   task automatic random_phase();
      int unsigned len;
      int unsigned rows;
      shuffle_weights();
      if ($urandom_range(7) == 0) begin
         len  = $urandom_range(13, 40);
         rows = 5;
      end else begin
         len  = $urandom_range(5, 12);
         rows = $urandom_range(5, 9);
      end
      run_grids(len, rows, $urandom_range(1, 2));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Smallest grid with an interior point: 5 x 5 gives exactly one result,
      // at the center, which is also the last of the grid.  The weights stay
      // at their reset values here.  The center sample is the most negative
      // value and its cross arms the most positive; the rest sit around zero.
      csr_write(CSR_ROW_LENGTH, 5);
      csr_write(CSR_ROW_COUNT, 5);
      for (int i = 0; i < 25; i++) begin
         if (i == 12) send_sample(SAMPLE_MIN);
         else if (i / 5 == 2 || i % 5 == 2) send_sample(SAMPLE_MAX);
         else send_sample(SAMPLE_W'(i % 3 - 1));
      end
      settle();

      // First segment: the source rarely idles, the sink stalls about half
      // the time, so the result queue fills and back-pressure reaches req.
      repeat (5) random_phase();

      // Second segment: the source is bursty and the sink nearly always ready.
      tx_idle_pct = 51;
      rx_idle_pct = 7;

      // Weights at their extremes drive the sum past 32 bits both ways.
      set_weights(WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX);
      run_grids(7, 6, 1);
      set_weights(WEIGHT_MIN, WEIGHT_MIN, WEIGHT_MIN, WEIGHT_MIN, WEIGHT_MIN);
      run_grids(6, 5, 1);
      set_weights(WEIGHT_MAX, WEIGHT_MIN, WEIGHT_MIN, WEIGHT_MAX, '0);
      run_grids(8, 5, 1);

      // Grids too small for any interior point, and the out-of-range sizes:
      // these beats must produce nothing at all.
      shuffle_weights();
      run_grids(4, 8, 1);
      run_grids(9, 4, 1);
      run_grids(0, 6, 1);
      run_grids(10, 0, 1);
      run_grids(1, 1, 2);

      // The largest register value for the row length, which the block clamps
      // to the full line memory.  A single-row grid is started at that length
      // and the row is then cut below the position, so the next beat wraps
      // straight to the start of a fresh grid.
      csr_write(CSR_ROW_LENGTH, 8191);
      csr_write(CSR_ROW_COUNT, 1);
      repeat (40) send_sample(pick_sample());
      settle();
      csr_write(CSR_ROW_LENGTH, 6);
      send_sample(pick_sample());
      settle();
      repeat (4) random_phase();

      // Last segment: neither side idles, the block runs at full rate.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      repeat (3) random_phase();

      // Geometry changes in the middle of a grid.  With the largest row count
      // the grid cannot end during this test.  The row is shortened while the
      // position sits past the new end, which only makes the next beat wrap
      // the row; shrinking never exposes a store entry that this grid did not
      // write.  Then the row count is cut below the current row, so the rest
      // of that row is stored without results and the position wraps to the
      // start of a grid.
      shuffle_weights();
      csr_write(CSR_ROW_LENGTH, 11);
      csr_write(CSR_ROW_COUNT, 32'h0000_FFFF);
      repeat (11 * 10 + 8) send_sample(pick_sample());
      settle();
      csr_write(CSR_ROW_LENGTH, 6);
      repeat (1 + 6 * 8) send_sample(pick_sample());
      settle();
      csr_write(CSR_ROW_COUNT, 9);
      repeat (6 + 6 * 9 * 2) send_sample(pick_sample());
      settle();

      if (fail_count == 0 && pending == 0) begin
         $display("fd4_laplacian_stencil_2d verification clean");
      end else begin
         $display("fd4_laplacian_stencil_2d verification failed");
      end
      $finish;
   end

   // Watchdog: beyond the slowest correct run, even with the longest stalls.
   initial begin
      #20_000_000;
      $display("fd4_laplacian_stencil_2d verification failed");
      $finish;
   end

endmodule
